// ----- rtl/swb_pkg.sv -----
`default_nettype none

package swb_pkg;

    // Fixed point format of all times and positions.
    localparam int FRAC_BITS = 16;

    // Edge positions and edge distances.
    localparam int EDGE_W = 34;
    localparam int NUM_W  = 35;

    // Divider: one quotient bit per stage, plus a setup and an output stage.
    localparam int DIV_STEPS = 32;
    localparam int DVD_W     = NUM_W + FRAC_BITS;
    localparam int HI_W      = DVD_W - DIV_STEPS;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // Front end stages, divider, two decision stages.
    localparam int FRONT_LAT = 3;
    localparam int BACK_LAT  = 2;
    localparam int LAT       = FRONT_LAT + DIV_LAT + BACK_LAT;

    localparam logic [30:0] FRAME_RESET = 31'd1092;

    // Near-zero speed: 10^8 * (vx^2 + vy^2) <= 2^(2*FRAC_BITS).
    localparam logic [31:0] SLOW_MAG = 32'd2048;
    localparam logic [63:0] SLOW_LIM = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

    // Contact normal codes.
    localparam logic [1:0] AXIS_MX = 2'd0;
    localparam logic [1:0] AXIS_PX = 2'd1;
    localparam logic [1:0] AXIS_MY = 2'd2;
    localparam logic [1:0] AXIS_PY = 2'd3;

    typedef struct packed {
        logic signed [31:0] own_center_x;
        logic signed [31:0] own_center_y;
        logic [30:0]        own_half_width;
        logic [30:0]        own_half_height;
        logic signed [31:0] mover_center_x;
        logic signed [31:0] mover_center_y;
        logic [30:0]        mover_half_width;
        logic [30:0]        mover_half_height;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
    } t_in_word;

    typedef struct packed {
        logic               hit;
        logic [1:0]         hit_axis;
        logic signed [31:0] contact_time;
    } t_out_word;

    typedef struct packed {
        logic slow;
        logic apart;
        logic ovx;
        logic ovy;
        logic vx_zero;
        logic vy_zero;
        logic vx_neg;
        logic vy_neg;
    } t_flags;

    typedef struct packed {
        logic signed [NUM_W-1:0] nin_x;
        logic signed [NUM_W-1:0] nout_x;
        logic signed [NUM_W-1:0] nin_y;
        logic signed [NUM_W-1:0] nout_y;
        logic signed [31:0]      vx;
        logic signed [31:0]      vy;
        t_flags                  flags;
    } t_front;

endpackage

`default_nettype wire

// ----- rtl/swept_box_collision_test.sv -----
// Swept box collision test.
// Input channel: i_valid, o_stall and i_word carry one box pair with the
// mover's velocity; a word is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid, i_stall and o_word carry the hit
// flag, contact face and entry time; one output word per input word, in order.
// Configuration: i_cfg_we writes i_cfg_data into the frame time register;
// write it only while no words are in flight.
// The pipeline has 39 register stages: three front end stages, a 34-stage
// divider (setup, one quotient bit per stage for 32 bits, saturation) and two
// decision stages. Four dividers run side by side, so one word enters and one
// leaves every cycle while the output is not held by i_stall.
// While the output word waits under i_stall the whole pipeline holds and
// o_stall is raised; bubbles and stalls never drop or repeat a word.
// Synchronous reset clears all valid bits and sets the frame time to 1092.
`default_nettype none

module swept_box_collision_test (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  swb_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  wire                i_stall,
    output swb_pkg::t_out_word o_word,
    input  wire                i_cfg_we,
    input  wire [30:0]         i_cfg_data
);
    import swb_pkg::*;

    logic [30:0]    r_frame_time;
    logic [LAT-1:0] r_vld;
    logic           adv;
    t_front         front;
    t_flags         r_flg [0:DIV_LAT-1];
    logic signed [31:0] tin_x, tout_x, tin_y, tout_y;

    // The pipeline moves whenever the output register can take a word.
    assign adv     = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[LAT-1];

    // Frame time register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= FRAME_RESET;
        end else if (i_cfg_we) begin
            r_frame_time <= i_cfg_data;
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    swb_front u_front (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_word  (i_word),
        .o_front (front)
    );

    swb_div u_div_in_x (.i_clk(i_clk), .i_en(adv), .i_num(front.nin_x),
                        .i_den(front.vx), .o_time(tin_x));
    swb_div u_div_out_x (.i_clk(i_clk), .i_en(adv), .i_num(front.nout_x),
                         .i_den(front.vx), .o_time(tout_x));
    swb_div u_div_in_y (.i_clk(i_clk), .i_en(adv), .i_num(front.nin_y),
                        .i_den(front.vy), .o_time(tin_y));
    swb_div u_div_out_y (.i_clk(i_clk), .i_en(adv), .i_num(front.nout_y),
                         .i_den(front.vy), .o_time(tout_y));

    // Flags ride alongside the dividers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_flg[0] <= front.flags;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    swb_back u_back (
        .i_clk        (i_clk),
        .i_en         (adv),
        .i_tin_x      (tin_x),
        .i_tout_x     (tout_x),
        .i_tin_y      (tin_y),
        .i_tout_y     (tout_y),
        .i_flags      (r_flg[DIV_LAT-1]),
        .i_frame_time (r_frame_time),
        .o_word       (o_word)
    );

endmodule

`default_nettype wire

// ----- rtl/swb_front.sv -----
`default_nettype none

module swb_front (
    input  wire             i_clk,
    input  wire             i_en,
    input  swb_pkg::t_in_word i_word,
    output swb_pkg::t_front   o_front
);
    import swb_pkg::*;

    t_in_word r_in;

    logic signed [EDGE_W-1:0] r_ol, r_or, r_ob, r_ot, r_l, r_r, r_b, r_t;
    logic signed [31:0]       r_vx, r_vy;
    logic                     r_small;
    logic [23:0]              r_sq_sum;

    logic [31:0] ax, ay;
    logic [23:0] sqx, sqy;
    logic        ovx, ovy;
    t_front      n_front;
    t_front      r_front;

    // Stage one: register the incoming word.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in <= i_word;
        end
    end

    // Stage two: box edges and the squared speed for the near-zero test.
    always_comb begin
        ax  = r_in.velocity_x[31] ? 32'(-r_in.velocity_x) : 32'(r_in.velocity_x);
        ay  = r_in.velocity_y[31] ? 32'(-r_in.velocity_y) : 32'(r_in.velocity_y);
        sqx = 24'(ax[11:0]) * 24'(ax[11:0]);
        sqy = 24'(ay[11:0]) * 24'(ay[11:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ol <= EDGE_W'(r_in.own_center_x) - EDGE_W'(signed'({1'b0, r_in.own_half_width}));
            r_or <= EDGE_W'(r_in.own_center_x) + EDGE_W'(signed'({1'b0, r_in.own_half_width}));
            r_ob <= EDGE_W'(r_in.own_center_y) - EDGE_W'(signed'({1'b0, r_in.own_half_height}));
            r_ot <= EDGE_W'(r_in.own_center_y) + EDGE_W'(signed'({1'b0, r_in.own_half_height}));
            r_l  <= EDGE_W'(r_in.mover_center_x)
                    - EDGE_W'(signed'({1'b0, r_in.mover_half_width}));
            r_r  <= EDGE_W'(r_in.mover_center_x)
                    + EDGE_W'(signed'({1'b0, r_in.mover_half_width}));
            r_b  <= EDGE_W'(r_in.mover_center_y)
                    - EDGE_W'(signed'({1'b0, r_in.mover_half_height}));
            r_t  <= EDGE_W'(r_in.mover_center_y)
                    + EDGE_W'(signed'({1'b0, r_in.mover_half_height}));
            r_vx     <= r_in.velocity_x;
            r_vy     <= r_in.velocity_y;
            r_small  <= (ax <= SLOW_MAG) && (ay <= SLOW_MAG);
            r_sq_sum <= sqx + sqy;
        end
    end

    // Stage three: edge distances in the order the velocity sign asks for.
    always_comb begin
        ovx = (r_ol < r_r) && (r_or > r_l);
        ovy = (r_ob < r_t) && (r_ot > r_b);

        if (r_vx[31]) begin
            n_front.nin_x  = NUM_W'(r_or) - NUM_W'(r_l);
            n_front.nout_x = NUM_W'(r_ol) - NUM_W'(r_r);
        end else begin
            n_front.nin_x  = NUM_W'(r_ol) - NUM_W'(r_r);
            n_front.nout_x = NUM_W'(r_or) - NUM_W'(r_l);
        end
        if (r_vy[31]) begin
            n_front.nin_y  = NUM_W'(r_ot) - NUM_W'(r_b);
            n_front.nout_y = NUM_W'(r_ob) - NUM_W'(r_t);
        end else begin
            n_front.nin_y  = NUM_W'(r_ob) - NUM_W'(r_t);
            n_front.nout_y = NUM_W'(r_ot) - NUM_W'(r_b);
        end
        n_front.vx            = r_vx;
        n_front.vy            = r_vy;
        n_front.flags.slow    = r_small && ({40'd0, r_sq_sum} <= SLOW_LIM);
        n_front.flags.apart   = !ovx || !ovy;
        n_front.flags.ovx     = ovx;
        n_front.flags.ovy     = ovy;
        n_front.flags.vx_zero = (r_vx == 32'sd0);
        n_front.flags.vy_zero = (r_vy == 32'sd0);
        n_front.flags.vx_neg  = r_vx[31];
        n_front.flags.vy_neg  = r_vy[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

`default_nettype wire

// ----- rtl/swb_div.sv -----
`default_nettype none

module swb_div (
    input  wire                                   i_clk,
    input  wire                                   i_en,
    input  wire signed [swb_pkg::NUM_W-1:0]       i_num,
    input  wire signed [31:0]                     i_den,
    output logic signed [31:0]                    o_time
);
    import swb_pkg::*;

    logic [NUM_W-1:0] mag;
    logic [31:0]      den_mag;
    logic [DVD_W-1:0] dvd;
    logic [HI_W-1:0]  hi;

    logic [31:0] r_rem [0:DIV_STEPS];
    logic [31:0] r_low [0:DIV_STEPS];
    logic [31:0] r_q   [0:DIV_STEPS];
    logic [31:0] r_den [0:DIV_STEPS];
    logic        r_neg [0:DIV_STEPS];
    logic        r_ovf [0:DIV_STEPS];

    logic signed [31:0] n_time;
    logic signed [31:0] r_time;

    // Setup: magnitudes, the shifted dividend, and the overflow check.
    always_comb begin
        mag     = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        den_mag = i_den[31] ? 32'(-i_den) : 32'(i_den);
        dvd     = {mag, {FRAC_BITS{1'b0}}};
        hi      = dvd[DVD_W-1:DIV_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 32'(hi);
            r_low[0] <= dvd[DIV_STEPS-1:0];
            r_q[0]   <= '0;
            r_den[0] <= den_mag;
            r_neg[0] <= i_num[NUM_W-1] != i_den[31];
            r_ovf[0] <= {{(33-HI_W){1'b0}}, hi} >= {1'b0, den_mag};
        end
    end

    // One restoring step per stage, one quotient bit each.
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [32:0] trial;
        logic        take;

        always_comb begin
            trial = {r_rem[s], r_low[s][31]};
            take  = trial >= {1'b0, r_den[s]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= take ? 32'(trial - {1'b0, r_den[s]}) : trial[31:0];
                r_low[s+1] <= {r_low[s][30:0], 1'b0};
                r_q[s+1]   <= {r_q[s][30:0], take};
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    // Sign and saturation to the signed 32-bit range.
    always_comb begin
        if (r_neg[DIV_STEPS]) begin
            if (r_ovf[DIV_STEPS] || (r_q[DIV_STEPS] > 32'h8000_0000)) begin
                n_time = T_MIN;
            end else begin
                n_time = 32'(-r_q[DIV_STEPS]);
            end
        end else begin
            if (r_ovf[DIV_STEPS] || r_q[DIV_STEPS][31]) begin
                n_time = T_MAX;
            end else begin
                n_time = r_q[DIV_STEPS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_time <= n_time;
        end
    end

    assign o_time = r_time;

endmodule

`default_nettype wire

// ----- rtl/swb_back.sv -----
`default_nettype none

module swb_back (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire signed [31:0]   i_tin_x,
    input  wire signed [31:0]   i_tout_x,
    input  wire signed [31:0]   i_tin_y,
    input  wire signed [31:0]   i_tout_y,
    input  swb_pkg::t_flags     i_flags,
    input  wire [30:0]          i_frame_time,
    output swb_pkg::t_out_word  o_word
);
    import swb_pkg::*;

    logic signed [31:0] tinx, toutx, tiny, touty, dt;
    logic               x_bad, y_bad, xface;

    logic               r_miss;
    logic signed [31:0] r_tin, r_tout;
    logic [1:0]         r_axis;
    t_out_word          r_word;

    // First decision stage: per-axis checks, later entry and earlier exit.
    always_comb begin
        dt    = signed'({1'b0, i_frame_time});
        tinx  = i_flags.vx_zero ? T_MIN : i_tin_x;
        toutx = i_flags.vx_zero ? T_MAX : i_tout_x;
        tiny  = i_flags.vy_zero ? T_MIN : i_tin_y;
        touty = i_flags.vy_zero ? T_MAX : i_tout_y;
        x_bad = (i_flags.vx_zero && !i_flags.ovx) || (toutx < 32'sd0) || (tinx > dt);
        y_bad = (i_flags.vy_zero && !i_flags.ovy) || (touty < 32'sd0) || (tiny > dt);
        xface = tinx > tiny;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_miss <= (i_flags.slow && i_flags.apart) || x_bad || y_bad;
            r_tin  <= xface ? tinx : tiny;
            r_tout <= (toutx < touty) ? toutx : touty;
            if (xface) begin
                r_axis <= i_flags.vx_neg ? AXIS_PX : AXIS_MX;
            end else begin
                r_axis <= i_flags.vy_neg ? AXIS_PY : AXIS_MY;
            end
        end
    end

    // Second decision stage: the intervals must overlap; a miss reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_miss && (r_tin < r_tout)) begin
                r_word.hit          <= 1'b1;
                r_word.hit_axis     <= r_axis;
                r_word.contact_time <= r_tin;
            end else begin
                r_word <= '0;
            end
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ----- rtl/swb_check.sv -----
`default_nettype none

module swb_check (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_valid,
    input wire                o_stall,
    input wire                o_valid,
    input wire                i_stall,
    input swb_pkg::t_out_word o_word
);
    import swb_pkg::*;

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_word)))
        else $error("output word changed under stall");

    // A miss carries no face and no time.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.hit) |-> (o_word.hit_axis == AXIS_MX
                                      && o_word.contact_time == 32'sd0))
        else $error("miss word carries a face or a time");

    // A stalled full output holds the input side back.
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while output stalled");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind swept_box_collision_test swb_check u_swb_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_word  (o_word)
);

`default_nettype wire

// ----- sim/tb_swept_box_collision_test.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_swept_box_collision_test;
    import swb_pkg::*;

    localparam int LATENCY = 39;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;
    logic      i_cfg_we;
    logic [30:0] i_cfg_data;

    // Model copy of the frame time register.
    logic [30:0] frame_len;
    t_out_word   expected_hits[$];
    int          error_count;
    bit          sink_idle_ok;
    bit          hold_sink;
    bit          source_gaps;

    swept_box_collision_test i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Signed magnitude quotient (num << 16) / den, truncated and saturated.
    function automatic longint entry_quotient(longint num, longint den);
        longint unsigned q;
        longint unsigned an;
        longint unsigned ad;
        bit neg;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an << FRAC_BITS) / ad;
        neg = (num < 0) != (den < 0);
        if (neg) begin
            return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        end
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    // Entry and exit time along one axis; returns 0 when that axis misses.
    function automatic bit axis_window(longint olo, longint ohi, longint lo, longint hi,
                                       longint v, longint dt,
                                       output longint tin, output longint tout);
        if (v > 0) begin
            tin = entry_quotient(olo - hi, v);
            tout = entry_quotient(ohi - lo, v);
        end else if (v < 0) begin
            tin = entry_quotient(ohi - lo, v);
            tout = entry_quotient(olo - hi, v);
        end else begin
            tin = 0;
            tout = 0;
            if (!(olo < hi && ohi > lo)) return 1'b0;
            tin = -64'sd2147483648;
            tout = 64'sd2147483647;
        end
        return !(tout < 0 || tin > dt);
    endfunction

    // Predicted collision result for one box pair.
    function automatic t_out_word sweep_collide(t_in_word w);
        t_out_word r;
        longint oL, oR, oB, oT, L, R, B, T, vx, vy, dt;
        longint tinx, toutx, tiny, touty, tin, tout;
        longint unsigned ax, ay;
        bit apart, slow;
        r = '0;
        vx = longint'(w.velocity_x);
        vy = longint'(w.velocity_y);
        dt = longint'({1'b0, frame_len});
        oL = longint'(w.own_center_x) - longint'({1'b0, w.own_half_width});
        oR = longint'(w.own_center_x) + longint'({1'b0, w.own_half_width});
        oB = longint'(w.own_center_y) - longint'({1'b0, w.own_half_height});
        oT = longint'(w.own_center_y) + longint'({1'b0, w.own_half_height});
        L = longint'(w.mover_center_x) - longint'({1'b0, w.mover_half_width});
        R = longint'(w.mover_center_x) + longint'({1'b0, w.mover_half_width});
        B = longint'(w.mover_center_y) - longint'({1'b0, w.mover_half_height});
        T = longint'(w.mover_center_y) + longint'({1'b0, w.mover_half_height});
        apart = (oL >= R || oR <= L) || (oB >= T || oT <= B);
        ax = (vx < 0) ? -vx : vx;
        ay = (vy < 0) ? -vy : vy;
        slow = (ax <= 2048 && ay <= 2048) &&
               (64'd100000000 * (ax * ax + ay * ay) <= (64'd1 << (2 * FRAC_BITS)));
        if (slow && apart) return r;
        if (!axis_window(oL, oR, L, R, vx, dt, tinx, toutx)) return r;
        if (!axis_window(oB, oT, B, T, vy, dt, tiny, touty)) return r;
        tin = (tinx > tiny) ? tinx : tiny;
        tout = (toutx < touty) ? toutx : touty;
        if (tin >= tout) return r;
        r.hit = 1'b1;
        if (tinx > tiny) begin
            r.hit_axis = (vx >= 0) ? AXIS_MX : AXIS_PX;
        end else begin
            r.hit_axis = (vy >= 0) ? AXIS_MY : AXIS_PY;
        end
        r.contact_time = tin[31:0];
        return r;
    endfunction

    // Offer one word, with a random gap first on one call in four on average when gaps are enabled.
    // The valid stays high afterwards so words can follow back to back.
    task automatic send_pair(t_in_word w);
        int gap;
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_word <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_hits.push_back(sweep_collide(w));
        @(negedge i_clk);
    endtask

    // Wait until every result has come back, then let the pipeline drain.
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (expected_hits.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_frame(logic [30:0] value);
        i_cfg_data <= value;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        frame_len = value;
    endtask

    function automatic t_in_word box_pair(int cx, int cy, int hw, int hh,
                                          int mx, int my, int mw, int mh,
                                          int vx, int vy);
        t_in_word w;
        w.own_center_x = cx;
        w.own_center_y = cy;
        w.own_half_width = hw[30:0];
        w.own_half_height = hh[30:0];
        w.mover_center_x = mx;
        w.mover_center_y = my;
        w.mover_half_width = mw[30:0];
        w.mover_half_height = mh[30:0];
        w.velocity_x = vx;
        w.velocity_y = vy;
        return w;
    endfunction

    // Random word; mostly small scenes that can actually collide.
    function automatic t_in_word random_pair();
        t_in_word w;
        logic [319:0] raw;
        int sel;
        int unsigned sh;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom};
            w = raw[$bits(t_in_word)-1:0];
        end else begin
            sh = $urandom_range(8, 20);
            w.own_center_x = $signed($urandom) >>> sh;
            w.own_center_y = $signed($urandom) >>> sh;
            w.own_half_width = 31'($urandom >> (sh + 1));
            w.own_half_height = 31'($urandom >> (sh + 1));
            w.mover_center_x = w.own_center_x + ($signed($urandom) >>> (sh + 1));
            w.mover_center_y = w.own_center_y + ($signed($urandom) >>> (sh + 1));
            w.mover_half_width = 31'($urandom >> (sh + 1));
            w.mover_half_height = 31'($urandom >> (sh + 1));
            w.velocity_x = $signed($urandom) >>> $urandom_range(0, 28);
            w.velocity_y = $signed($urandom) >>> $urandom_range(0, 28);
            if (sel == 2) w.velocity_x = 0;
            if (sel == 3) w.velocity_y = $signed($urandom) >>> 20;
            if (sel == 4) w.velocity_x = $signed($urandom) >>> 20;
        end
        return w;
    endfunction

    // Result checker: compare each accepted word with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected result word %h", o_word);
                error_count++;
            end else begin
                e = expected_hits.pop_front();
                if (o_word.hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, o_word.hit);
                    error_count++;
                end
                if (o_word.hit_axis !== e.hit_axis) begin
                    $error("hit_axis: expected %0d, got %0d", e.hit_axis, o_word.hit_axis);
                    error_count++;
                end
                if (o_word.contact_time !== e.contact_time) begin
                    $error("contact_time: expected %0d, got %0d",
                           e.contact_time, o_word.contact_time);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall: random bursts, a long hold-off on request, none late.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_stall <= 1'b1;
                for (n = 0; n < 120; n++) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_sink = 1'b0;
            end else if (sink_idle_ok && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                n = $urandom_range(1, 18);
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic test_extremes();
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, -32'h30000, 0, 32'h10000, 32'h10000,
                           32'h40000, 0));
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 32'h30000, 0, 32'h10000, 32'h10000,
                           -32'h40000, 0));
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 0, -32'h30000, 32'h10000, 32'h10000,
                           0, 32'h40000));
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 0, 32'h30000, 32'h10000, 32'h10000,
                           0, -32'h40000));
        // Both components zero and overlapping: hit at the earliest time.
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 32'h8000, 0, 32'h10000, 32'h10000,
                           0, 0));
        // Zero component with that axis apart: miss.
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 0, 32'h50000, 32'h10000, 32'h10000,
                           32'h1000, 0));
        // Near-zero speed, boxes touching only: miss, also just under the speed limit; just over it: hit.
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 32'h20000, 0, 32'h10000, 32'h10000,
                           -6, 0));
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 32'h20000, 0, 32'h10000, 32'h10000,
                           -7, 0));
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 32'h20000, 0, 32'h10000, 32'h10000,
                           -4, -5));
        // Already overlapping and moving: negative entry time.
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, 32'h8000, 32'h4000, 32'h10000,
                           32'h10000, 32'h1000, -32'h1000));
        // Diagonal tie in entry times picks the y face.
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, -32'h30000, -32'h30000, 32'h10000,
                           32'h10000, 32'h40000, 32'h40000));
        // Saturating quotients with extreme positions.
        send_pair(box_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           1, 32'h80000000));
        send_pair(box_pair(32'h80000000, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                           0, 0, 32'h80000000, 32'h7FFFFFFF));
        send_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(box_pair(-1, -1, 32'h7FFFFFFF, 32'h7FFFFFFF, -1, -1, 32'h7FFFFFFF,
                           32'h7FFFFFFF, -1, -1));
        // Entry exactly at and just past the frame time.
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, -32'h20000 - 1092, 0, 32'h10000,
                           32'h10000, 32'h10000, 0));
        send_pair(box_pair(0, 0, 32'h10000, 32'h10000, -32'h20000 - 1093, 0, 32'h10000,
                           32'h10000, 32'h10000, 0));
        drain_pipe();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) send_pair(random_pair());
        drain_pipe();
    endtask

    task automatic test_frame_sweep();
        write_frame(31'd0);
        test_random(150);
        write_frame(31'h7FFFFFFF);
        test_random(150);
        write_frame(31'h10000);
        test_random(150);
    endtask

    // Hold the receiver while words keep coming so the pipeline backs up.
    task automatic test_backpressure();
        hold_sink = 1'b1;
        source_gaps = 1'b0;
        test_random(100);
        source_gaps = 1'b1;
    endtask

    task automatic test_streaming();
        write_frame(31'h4000);
        sink_idle_ok = 1'b0;
        source_gaps = 1'b0;
        test_random(250);
    endtask

    initial begin
        error_count = 0;
        frame_len = FRAME_RESET;
        sink_idle_ok = 1'b1;
        hold_sink = 1'b0;
        source_gaps = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_random(200);
        test_frame_sweep();
        test_backpressure();
        test_streaming();
        if (error_count == 0 && expected_hits.size() == 0) begin
            $display("PASS swept_box_collision_test");
        end else begin
            if (expected_hits.size() != 0) $error("%0d results missing", expected_hits.size());
            $display("FAIL swept_box_collision_test");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #4ms;
        $display("FAIL swept_box_collision_test");
        $finish;
    end

endmodule

`default_nettype wire
